// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion shorthands for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: rtl/core/sdaf_pkg.sv
// ----------------------------------------------------------------------------
// sdaf_pkg
// Types, constants and helpers for the signed decimal ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdaf_pkg;

   // field widths
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 8;

   // default for the digit limit
   localparam int unsigned MAX_DIGITS_DEF = 10;

   // binary bits retired by each double-dabble stage
   localparam int unsigned DD_BITS = 4;

   // mode codes
   localparam logic CMD_INT  = 1'b0;
   localparam logic CMD_REAL = 1'b1;

   // ascii codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

   // largest magnitude printable in ndig digits, clamped to 32 bits
   function automatic logic [VALUE_W-1:0] digit_cap(input int unsigned ndig);
      logic [63:0] lim;
      lim = 64'd1;
      for (int n = 0; n < 10; n++) begin
         if (n < int'(ndig)) begin
            lim = lim * 64'd10;
         end
      end
      lim = lim - 64'd1;
      if (lim > 64'h0000_0000_FFFF_FFFF) begin
         lim = 64'h0000_0000_FFFF_FFFF;
      end
      return lim[VALUE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_decimal_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_unit
// Turns a signed 32-bit value (integer or Q16.16) into decimal ASCII text,
// one character per beat, most significant first, tlast on the final one.
// Throughput: one character per cycle while rsp_tready is high; each value
// holds the output until all of its text (1 to 11 characters) is sent
// by the character sequencer. Front end: input capture, sign and magnitude,
// scaling, 8 double-dabble stages of 4 bits each, then the align stage.
// Reset: synchronous, active high; clears all valid bits and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module signed_decimal_ascii_formatter_unit
   import sdaf_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input beat
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [31:0]       req_tdata,   // [31:0] value
   input  wire logic [0:0]        req_tuser,   // [0] cmd
   // result beat
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] text_char
   output logic                   rsp_tlast    // last_char
);

   localparam int unsigned BCD_W     = 4 * MAX_DIGITS;
   localparam int unsigned CNT_W     = $clog2(MAX_DIGITS + 1);
   localparam int unsigned DD_STAGES = VALUE_W / DD_BITS;
   localparam logic [VALUE_W-1:0] DIGIT_CAP = digit_cap(MAX_DIGITS);
   // x / 10 as (x * 205) >> 11, exact below 1029
   localparam logic [14:0] DIV10_MUL = 15'd205;
   localparam int unsigned DIV10_SH  = 11;

   typedef enum logic [2:0] {
      PH_SIGN,
      PH_INT,
      PH_POINT,
      PH_FRAC_HI,
      PH_FRAC_LO
   } phase_type;

   // ------------------------------------------------------------------------
   // stage 0: input capture
   // ------------------------------------------------------------------------
   logic               in_vld_ff;
   logic               in_cmd_ff;
   logic [VALUE_W-1:0] in_val_ff;
   logic               in_rdy;
   logic               mg_rdy;

   assign in_rdy     = !in_vld_ff || mg_rdy;
   assign req_tready = in_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_rdy) begin
         in_vld_ff <= req_tvalid;
      end
      if (in_rdy && req_tvalid) begin
         in_cmd_ff <= req_tuser[0];
         in_val_ff <= req_tdata;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: sign and magnitude
   // ------------------------------------------------------------------------
   logic               mg_vld_ff;
   logic               mg_cmd_ff;
   logic               mg_neg_ff;
   logic [VALUE_W-1:0] mg_mag_ff;
   logic [VALUE_W-1:0] mg_mag_in;
   logic               sc_rdy;

   assign mg_rdy    = !mg_vld_ff || sc_rdy;
   // unsigned negate keeps the most negative value exact
   assign mg_mag_in = in_val_ff[VALUE_W-1] ? (VALUE_W'(0) - in_val_ff) : in_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_vld_ff <= 1'b0;
      end else if (mg_rdy) begin
         mg_vld_ff <= in_vld_ff;
      end
      if (mg_rdy && in_vld_ff) begin
         mg_cmd_ff <= in_cmd_ff;
         mg_neg_ff <= in_val_ff[VALUE_W-1];
         mg_mag_ff <= mg_mag_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: pick integer part, saturate, scale fraction to hundredths
   // ------------------------------------------------------------------------
   logic               sc_vld_ff;
   logic               sc_cmd_ff;
   logic               sc_neg_ff;
   logic [VALUE_W-1:0] sc_num_ff;
   logic [6:0]         sc_frac_ff;
   logic [VALUE_W-1:0] sc_pre;
   logic [VALUE_W-1:0] sc_num_in;
   logic [22:0]        sc_prod;
   logic               dd_rdy [DD_STAGES];

   assign sc_rdy    = !sc_vld_ff || dd_rdy[0];
   assign sc_pre    = (mg_cmd_ff == CMD_REAL) ? {16'd0, mg_mag_ff[31:16]} : mg_mag_ff;
   assign sc_num_in = (sc_pre > DIGIT_CAP) ? DIGIT_CAP : sc_pre;
   assign sc_prod   = {7'd0, mg_mag_ff[15:0]} * 23'd100;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else if (sc_rdy) begin
         sc_vld_ff <= mg_vld_ff;
      end
      if (sc_rdy && mg_vld_ff) begin
         sc_cmd_ff  <= mg_cmd_ff;
         sc_neg_ff  <= mg_neg_ff;
         sc_num_ff  <= sc_num_in;
         sc_frac_ff <= sc_prod[22:16];
      end
   end

   // ------------------------------------------------------------------------
   // double-dabble stages: DD_BITS shift-and-adjust steps each
   // ------------------------------------------------------------------------
   logic               dd_vld_ff  [DD_STAGES];
   logic               dd_cmd_ff  [DD_STAGES];
   logic               dd_neg_ff  [DD_STAGES];
   logic [3:0]         dd_fhi_ff  [DD_STAGES];
   logic [3:0]         dd_flo_ff  [DD_STAGES];
   logic [BCD_W-1:0]   dd_bcd_ff  [DD_STAGES];
   logic [VALUE_W-1:0] dd_bin_ff  [DD_STAGES];

   logic               dd_src_vld [DD_STAGES];
   logic               dd_src_cmd [DD_STAGES];
   logic               dd_src_neg [DD_STAGES];
   logic [3:0]         dd_src_fhi [DD_STAGES];
   logic [3:0]         dd_src_flo [DD_STAGES];
   logic [BCD_W-1:0]   dd_src_bcd [DD_STAGES];
   logic [VALUE_W-1:0] dd_src_bin [DD_STAGES];
   logic [BCD_W-1:0]   dd_bcd_in  [DD_STAGES];
   logic [VALUE_W-1:0] dd_bin_in  [DD_STAGES];

   // fraction hundredths split into tens and units
   logic [14:0] fr_q;
   logic [3:0]  fr_hi;
   logic [6:0]  fr_lo;
   logic        al_rdy;

   assign fr_q  = {8'd0, sc_frac_ff} * DIV10_MUL;
   assign fr_hi = fr_q[DIV10_SH +: 4];
   assign fr_lo = sc_frac_ff - 7'({3'd0, fr_hi} * 7'd10);

   for (genvar d = 0; d < DD_STAGES; d++) begin : g_dd
      if (d == 0) begin : g_first
         assign dd_src_vld[d] = sc_vld_ff;
         assign dd_src_cmd[d] = sc_cmd_ff;
         assign dd_src_neg[d] = sc_neg_ff;
         assign dd_src_fhi[d] = fr_hi;
         assign dd_src_flo[d] = fr_lo[3:0];
         assign dd_src_bcd[d] = '0;
         assign dd_src_bin[d] = sc_num_ff;
      end else begin : g_next
         assign dd_src_vld[d] = dd_vld_ff[d-1];
         assign dd_src_cmd[d] = dd_cmd_ff[d-1];
         assign dd_src_neg[d] = dd_neg_ff[d-1];
         assign dd_src_fhi[d] = dd_fhi_ff[d-1];
         assign dd_src_flo[d] = dd_flo_ff[d-1];
         assign dd_src_bcd[d] = dd_bcd_ff[d-1];
         assign dd_src_bin[d] = dd_bin_ff[d-1];
      end

      // add 3 to every digit of 5 or more, then shift one bit in
      always_comb begin
         dd_bcd_in[d] = dd_src_bcd[d];
         dd_bin_in[d] = dd_src_bin[d];
         for (int s = 0; s < DD_BITS; s++) begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
               if (dd_bcd_in[d][4*k +: 4] >= 4'd5) begin
                  dd_bcd_in[d][4*k +: 4] = dd_bcd_in[d][4*k +: 4] + 4'd3;
               end
            end
            {dd_bcd_in[d], dd_bin_in[d]} = {dd_bcd_in[d][BCD_W-2:0], dd_bin_in[d], 1'b0};
         end
      end
   end

   // a stage takes a beat when empty or when the one after it moves
   always_comb begin
      dd_rdy[DD_STAGES-1] = !dd_vld_ff[DD_STAGES-1] || al_rdy;
      for (int d = int'(DD_STAGES) - 2; d >= 0; d--) begin
         dd_rdy[d] = !dd_vld_ff[d] || dd_rdy[d+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < DD_STAGES; d++) begin
         if (reset) begin
            dd_vld_ff[d] <= 1'b0;
         end else if (dd_rdy[d]) begin
            dd_vld_ff[d] <= dd_src_vld[d];
         end
         if (dd_rdy[d] && dd_src_vld[d]) begin
            dd_cmd_ff[d] <= dd_src_cmd[d];
            dd_neg_ff[d] <= dd_src_neg[d];
            dd_fhi_ff[d] <= dd_src_fhi[d];
            dd_flo_ff[d] <= dd_src_flo[d];
            dd_bcd_ff[d] <= dd_bcd_in[d];
            dd_bin_ff[d] <= dd_bin_in[d];
         end
      end
   end

   // ------------------------------------------------------------------------
   // align stage: count significant digits, push the leading one to the top
   // ------------------------------------------------------------------------
   logic             al_vld_ff;
   logic             al_cmd_ff;
   logic             al_neg_ff;
   logic [3:0]       al_fhi_ff;
   logic [3:0]       al_flo_ff;
   logic [BCD_W-1:0] al_dig_ff;
   logic [CNT_W-1:0] al_ndig_ff;
   logic [CNT_W-1:0] al_ndig_in;
   logic [CNT_W+1:0] al_sh;
   logic [BCD_W-1:0] al_dig_in;
   logic             ser_rdy;

   assign al_rdy = !al_vld_ff || ser_rdy;

   always_comb begin
      // zero still prints one digit
      al_ndig_in = CNT_W'(1);
      for (int i = 1; i < MAX_DIGITS; i++) begin
         if (dd_bcd_ff[DD_STAGES-1][4*i +: 4] != 4'd0) begin
            al_ndig_in = CNT_W'(i + 1);
         end
      end
      al_sh     = {CNT_W'(MAX_DIGITS) - al_ndig_in, 2'b00};
      al_dig_in = dd_bcd_ff[DD_STAGES-1] << al_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         al_vld_ff <= 1'b0;
      end else if (al_rdy) begin
         al_vld_ff <= dd_vld_ff[DD_STAGES-1];
      end
      if (al_rdy && dd_vld_ff[DD_STAGES-1]) begin
         al_cmd_ff  <= dd_cmd_ff[DD_STAGES-1];
         al_neg_ff  <= dd_neg_ff[DD_STAGES-1];
         al_fhi_ff  <= dd_fhi_ff[DD_STAGES-1];
         al_flo_ff  <= dd_flo_ff[DD_STAGES-1];
         al_dig_ff  <= al_dig_in;
         al_ndig_ff <= al_ndig_in;
      end
   end

   // ------------------------------------------------------------------------
   // character sequencer and output register
   // ------------------------------------------------------------------------
   logic              ser_vld_ff;
   phase_type         ser_phase_ff;
   logic [BCD_W-1:0]  ser_dig_ff;
   logic [CNT_W-1:0]  ser_dleft_ff;
   logic              ser_cmd_ff;
   logic [3:0]        ser_fhi_ff;
   logic [3:0]        ser_flo_ff;
   logic              rsp_tvalid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;

   logic              ser_vld_in;
   phase_type         ser_phase_in;
   logic [BCD_W-1:0]  ser_dig_in;
   logic [CNT_W-1:0]  ser_dleft_in;
   logic              ser_cmd_in;
   logic [3:0]        ser_fhi_in;
   logic [3:0]        ser_flo_in;
   logic              rsp_tvalid_in;
   logic [CHAR_W-1:0] rsp_char_in;
   logic              rsp_last_in;

   logic              out_load;
   logic [CHAR_W-1:0] cur_char;
   logic              cur_last;
   phase_type         cur_next;

   assign out_load = ser_vld_ff && (!rsp_tvalid_ff || rsp_tready);
   assign ser_rdy  = !ser_vld_ff || (out_load && cur_last);

   // character of the current phase
   always_comb begin
      case (ser_phase_ff)
         PH_SIGN: begin
            cur_char = ASCII_MINUS;
            cur_last = 1'b0;
            cur_next = PH_INT;
         end
         PH_INT: begin
            cur_char = ASCII_ZERO + {4'd0, ser_dig_ff[BCD_W-1 -: 4]};
            cur_last = (ser_dleft_ff == CNT_W'(1)) && (ser_cmd_ff == CMD_INT);
            cur_next = (ser_dleft_ff == CNT_W'(1)) ? PH_POINT : PH_INT;
         end
         PH_POINT: begin
            cur_char = ASCII_POINT;
            cur_last = 1'b0;
            cur_next = PH_FRAC_HI;
         end
         PH_FRAC_HI: begin
            cur_char = ASCII_ZERO + {4'd0, ser_fhi_ff};
            cur_last = 1'b0;
            cur_next = PH_FRAC_LO;
         end
         PH_FRAC_LO: begin
            cur_char = ASCII_ZERO + {4'd0, ser_flo_ff};
            cur_last = 1'b1;
            cur_next = PH_SIGN;
         end
         default: begin
            cur_char = ASCII_ZERO;
            cur_last = 1'b1;
            cur_next = PH_SIGN;
         end
      endcase
   end

   // next values of sequencer and output register
   always_comb begin
      ser_vld_in    = ser_vld_ff;
      ser_phase_in  = ser_phase_ff;
      ser_dig_in    = ser_dig_ff;
      ser_dleft_in  = ser_dleft_ff;
      ser_cmd_in    = ser_cmd_ff;
      ser_fhi_in    = ser_fhi_ff;
      ser_flo_in    = ser_flo_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;

      // hand one character to the output register
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_char_in   = cur_char;
         rsp_last_in   = cur_last;
         ser_phase_in  = cur_next;
         if (ser_phase_ff == PH_INT) begin
            ser_dig_in   = ser_dig_ff << 4;
            ser_dleft_in = ser_dleft_ff - CNT_W'(1);
         end
         if (cur_last) begin
            ser_vld_in = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      // take the next value as the previous one finishes
      if (ser_rdy && al_vld_ff) begin
         ser_vld_in   = 1'b1;
         ser_phase_in = al_neg_ff ? PH_SIGN : PH_INT;
         ser_dig_in   = al_dig_ff;
         ser_dleft_in = al_ndig_ff;
         ser_cmd_in   = al_cmd_ff;
         ser_fhi_in   = al_fhi_ff;
         ser_flo_in   = al_flo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff    <= 1'b0;
         ser_phase_ff  <= PH_SIGN;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         ser_vld_ff    <= ser_vld_in;
         ser_phase_ff  <= ser_phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      ser_dig_ff   <= ser_dig_in;
      ser_dleft_ff <= ser_dleft_in;
      ser_cmd_ff   <= ser_cmd_in;
      ser_fhi_ff   <= ser_fhi_in;
      ser_flo_ff   <= ser_flo_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `ASSERT_ALWAYS(a_align_holds_on_stall, clock, reset, (al_vld_ff && !ser_rdy) |=> al_vld_ff)
   `ASSERT_ALWAYS(a_int_digits_left, clock, reset, (ser_vld_ff && ser_phase_ff == PH_INT) |-> (ser_dleft_ff != '0))
   `ASSERT_ALWAYS(a_point_real_only, clock, reset, (ser_vld_ff && ser_phase_ff == PH_POINT) |-> (ser_cmd_ff == CMD_REAL))
   `ASSERT_ALWAYS(a_char_set, clock, reset, rsp_tvalid_ff |-> ((rsp_char_ff >= ASCII_ZERO && rsp_char_ff <= ASCII_NINE) || rsp_char_ff == ASCII_MINUS || rsp_char_ff == ASCII_POINT))
   `ASSERT_NEVER(a_real_ends_on_fraction, clock, reset, out_load && cur_last && ser_phase_ff == PH_INT && ser_cmd_ff == CMD_REAL)

endmodule

`default_nettype wire
